// File: hw/rtl/tgov_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Thermal energy action governor package
// Shared constants, register indexes and reset values of the governor.
// ----------------------------------------------------------------------------
package tgov_pkg;

   localparam int unsigned QUO_W         = 15;
   localparam int unsigned HEAT_DIV_W    = 16;
   localparam int unsigned ENERGY_DIV_W  = 24;
   localparam int unsigned NEXT_HEAT_W   = 23;

   localparam logic [23:0] CHARGE_FULL   = 24'd8388608;
   localparam logic [18:0] SLACK         = 19'd33;

   localparam logic [15:0] ONE_Q15       = 16'd32768;
   localparam logic [15:0] HEAT_GATE     = 16'd9830;
   localparam logic [15:0] ENERGY_MID    = 16'd16384;
   localparam logic [15:0] ENERGY_HIGH   = 16'd26214;
   localparam logic [15:0] SHADE_BOOST   = 16'd6554;
   localparam logic [15:0] SHADE_MIN     = 16'd9830;
   localparam logic [15:0] MIST_HALF     = 16'd16384;

   localparam logic [15:0] SAFE_TEMPERATURE_RESET = 16'd8960;
   localparam logic [15:0] HARM_TEMPERATURE_RESET = 16'd11520;
   localparam logic [23:0] CHARGE_MINIMUM_RESET   = 24'd1677722;
   localparam logic [15:0] HEAT_WEIGHT_RESET      = 16'd9830;
   localparam logic [15:0] ENERGY_WEIGHT_RESET    = 16'd9830;
   localparam logic [16:0] RISK_CEILING_RESET     = 17'd9830;
   localparam logic [31:0] SHADE_DRAIN_RESET      = 32'd3579139;
   localparam logic [31:0] MIST_DRAIN_RESET       = 32'd14316558;

   typedef enum logic [2:0] {
      CSR_SAFE_TEMPERATURE = 3'd0,
      CSR_HARM_TEMPERATURE = 3'd1,
      CSR_CHARGE_MINIMUM   = 3'd2,
      CSR_HEAT_WEIGHT      = 3'd3,
      CSR_ENERGY_WEIGHT    = 3'd4,
      CSR_RISK_CEILING     = 3'd5,
      CSR_SHADE_DRAIN      = 3'd6,
      CSR_MIST_DRAIN       = 3'd7
   } csr_index_type;

endpackage
`default_nettype wire

// File: hw/rtl/tgov_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Governor pipelined divider
// Restoring fraction divider, one quotient bit per register stage. The
// dividend must be below the divisor; the result is floor(num * 2^QW / den).
// ----------------------------------------------------------------------------
module tgov_div #(
   parameter int unsigned W  = tgov_pkg::HEAT_DIV_W,
   parameter int unsigned QW = tgov_pkg::QUO_W
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [W-1:0]  num,
   input  wire logic [W-1:0]  den,
   output logic      [QW-1:0] quo
);

   logic [W-1:0]  rem_ff [QW];
   logic [W-1:0]  den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [W-1:0]  rem_src;
      logic [W-1:0]  den_src;
      logic [QW-1:0] quo_src;
      logic [W:0]    shifted;
      logic [W:0]    diff;
      logic          ge;
      logic [W-1:0]  rem_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      assign shifted = {rem_src, 1'b0};
      assign diff    = shifted - {1'b0, den_src};
      assign ge      = shifted >= {1'b0, den_src};
      assign rem_in  = ge ? diff[W-1:0] : shifted[W-1:0];
      assign quo_in  = {quo_src[QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule
`default_nettype wire

// File: hw/rtl/thermal_energy_action_governor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Thermal energy action governor
// Rates a cooling action from one temperature and charge sample and predicts
// the risks, charge and continue or stop verdict after it.
// ----------------------------------------------------------------------------
// The unit takes one sample beat per clock cycle while req_tready is high and
// returns one result beat for each, in order. Each sample passes through two
// pairs of 15-stage divider pipelines, which form the current and the predicted
// risk ramps. A two-entry output buffer lets the pipeline run while a result
// waits, so req_tready drops only once two results are held. Registers are to
// be written through the csr port only while no sample is in flight; the unit
// itself does not enforce this.
module thermal_energy_action_governor_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // temperature, charge, given_shade_enable, given_shade_level, given_mist_on,
   // given_mist_level, zero fill
   input  wire logic [79:0]  req_tdata,
   // action
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // shade_enable, shade_level, mist_on, mist_level, next_heat_risk,
   // next_energy_risk, next_potential, next_risk_sum, next_charge, verdict,
   // zero fill
   output logic      [127:0] rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   localparam int unsigned QW = tgov_pkg::QUO_W;

   typedef struct packed {
      logic        shade_enable;
      logic [15:0] shade_level;
      logic        mist_on;
      logic [15:0] mist_level;
   } act_type;

   typedef struct packed {
      logic               action;
      logic signed [15:0] temperature;
      logic [23:0]        charge;
      act_type            given;
   } in_type;

   typedef struct packed {
      logic               action;
      act_type            given;
      logic [23:0]        charge;
      logic signed [16:0] t_diff;
      logic signed [16:0] h_span;
      logic               h_zero;
      logic               h_one;
      logic               e_zero;
      logic               e_one;
   } side1_type;

   typedef struct packed {
      act_type            act;
      logic [15:0]        s_eff;
      logic [15:0]        m_eff;
      logic [15:0]        h;
      logic [15:0]        e;
      logic [23:0]        charge;
      logic signed [16:0] t_diff;
      logic signed [16:0] h_span;
   } sta_type;

   typedef struct packed {
      act_type            act;
      logic [23:0]        charge;
      logic signed [24:0] n_heat;
      logic signed [16:0] h_span;
      logic [47:0]        shade_prod;
      logic [47:0]        mist_prod;
      logic [31:0]        h_sq;
      logic [31:0]        e_sq;
   } stb_type;

   typedef struct packed {
      act_type     act;
      logic [23:0] charge;
      logic [48:0] drain;
      logic [47:0] p_h;
      logic [47:0] p_e;
      logic        nh_zero;
      logic        nh_one;
      logic [22:0] nh_num;
      logic [22:0] nh_den;
   } stc_type;

   typedef struct packed {
      act_type     act;
      logic [23:0] nc;
      logic [17:0] cp;
      logic        nh_zero;
      logic        nh_one;
      logic [22:0] nh_num;
      logic [22:0] nh_den;
   } std_type;

   typedef struct packed {
      act_type     act;
      logic [23:0] nc;
      logic [17:0] cp;
      logic        nh_zero;
      logic        nh_one;
      logic        ne_zero;
      logic        ne_one;
   } side2_type;

   typedef struct packed {
      act_type     act;
      logic [23:0] nc;
      logic [17:0] cp;
      logic [15:0] nh;
      logic [15:0] ne;
      logic [31:0] nh_sq;
      logic [31:0] ne_sq;
      logic [31:0] rs_h;
      logic [31:0] rs_e;
   } ste_type;

   typedef struct packed {
      act_type     act;
      logic [23:0] nc;
      logic [17:0] cp;
      logic [15:0] nh;
      logic [15:0] ne;
      logic [47:0] p_h;
      logic [47:0] p_e;
      logic [17:0] nr;
   } stf_type;

   // Configuration registers.
   logic [15:0] safe_temp_ff;
   logic [15:0] harm_temp_ff;
   logic [23:0] charge_min_ff;
   logic [15:0] heat_weight_ff;
   logic [15:0] energy_weight_ff;
   logic [16:0] risk_ceiling_ff;
   logic [31:0] shade_drain_ff;
   logic [31:0] mist_drain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_temp_ff     <= tgov_pkg::SAFE_TEMPERATURE_RESET;
         harm_temp_ff     <= tgov_pkg::HARM_TEMPERATURE_RESET;
         charge_min_ff    <= tgov_pkg::CHARGE_MINIMUM_RESET;
         heat_weight_ff   <= tgov_pkg::HEAT_WEIGHT_RESET;
         energy_weight_ff <= tgov_pkg::ENERGY_WEIGHT_RESET;
         risk_ceiling_ff  <= tgov_pkg::RISK_CEILING_RESET;
         shade_drain_ff   <= tgov_pkg::SHADE_DRAIN_RESET;
         mist_drain_ff    <= tgov_pkg::MIST_DRAIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tgov_pkg::CSR_SAFE_TEMPERATURE: begin
               safe_temp_ff <= csr_data[15:0];
            end
            tgov_pkg::CSR_HARM_TEMPERATURE: begin
               harm_temp_ff <= csr_data[15:0];
            end
            tgov_pkg::CSR_CHARGE_MINIMUM: begin
               charge_min_ff <= csr_data[23:0];
            end
            tgov_pkg::CSR_HEAT_WEIGHT: begin
               heat_weight_ff <= csr_data[15:0];
            end
            tgov_pkg::CSR_ENERGY_WEIGHT: begin
               energy_weight_ff <= csr_data[15:0];
            end
            tgov_pkg::CSR_RISK_CEILING: begin
               risk_ceiling_ff <= csr_data[16:0];
            end
            tgov_pkg::CSR_SHADE_DRAIN: begin
               shade_drain_ff <= csr_data;
            end
            tgov_pkg::CSR_MIST_DRAIN: begin
               mist_drain_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Pipeline advance and output buffer control.
   logic    en;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    take;
   logic    out_load_new, out_load_skid, skid_load;
   logic [127:0] out_data_ff, skid_data_ff, res_data;
   logic    vf_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign take       = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Input register.
   in_type in_ff;
   logic   v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff.action             <= req_tuser;
         in_ff.temperature        <= req_tdata[15:0];
         in_ff.charge             <= req_tdata[39:16];
         in_ff.given.shade_enable <= req_tdata[40];
         in_ff.given.shade_level  <= req_tdata[56:41];
         in_ff.given.mist_on      <= req_tdata[57];
         in_ff.given.mist_level   <= req_tdata[73:58];
      end
   end

   // Current risk ramps enter the first divider pair.
   side1_type side1_in;
   logic [15:0] h_div_num, h_div_den;
   logic [23:0] e_div_num, e_div_den;

   always_comb begin
      side1_in.action = in_ff.action;
      side1_in.given  = in_ff.given;
      side1_in.given.shade_level = (in_ff.given.shade_level > tgov_pkg::ONE_Q15) ?
                                   tgov_pkg::ONE_Q15 : in_ff.given.shade_level;
      side1_in.given.mist_level  = (in_ff.given.mist_level > tgov_pkg::ONE_Q15) ?
                                   tgov_pkg::ONE_Q15 : in_ff.given.mist_level;
      side1_in.charge = in_ff.charge;
      side1_in.t_diff = $signed({in_ff.temperature[15], in_ff.temperature})
                        - $signed({safe_temp_ff[15], safe_temp_ff});
      side1_in.h_span = $signed({harm_temp_ff[15], harm_temp_ff})
                        - $signed({safe_temp_ff[15], safe_temp_ff});
      side1_in.h_zero = side1_in.t_diff <= 17'sd0;
      side1_in.h_one  = in_ff.temperature >= $signed(harm_temp_ff);
      side1_in.e_zero = in_ff.charge >= tgov_pkg::CHARGE_FULL;
      side1_in.e_one  = in_ff.charge <= charge_min_ff;
      h_div_num = side1_in.t_diff[15:0];
      h_div_den = side1_in.h_span[15:0];
      e_div_num = tgov_pkg::CHARGE_FULL - in_ff.charge;
      e_div_den = tgov_pkg::CHARGE_FULL - charge_min_ff;
   end

   logic [QW-1:0] h_quo, e_quo;

   tgov_div #(.W(tgov_pkg::HEAT_DIV_W), .QW(QW)) u_heat_div (
      .clock (clock), .en (en), .num (h_div_num), .den (h_div_den), .quo (h_quo)
   );

   tgov_div #(.W(tgov_pkg::ENERGY_DIV_W), .QW(QW)) u_energy_div (
      .clock (clock), .en (en), .num (e_div_num), .den (e_div_den), .quo (e_quo)
   );

   side1_type side1_ff [QW];
   logic [QW-1:0] v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
      end else if (en) begin
         v1_ff <= {v1_ff[QW-2:0], v0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff[0] <= side1_in;
         for (int i = 1; i < QW; i++) begin
            side1_ff[i] <= side1_ff[i-1];
         end
      end
   end

   // Stage A: current risks and the action to evaluate.
   side1_type s1;
   sta_type   sta_in, sta_ff;
   logic      va_ff;
   logic [16:0] h_boost;

   always_comb begin
      s1 = side1_ff[QW-1];
      sta_in.h = s1.h_zero ? 16'd0 : (s1.h_one ? tgov_pkg::ONE_Q15 : {1'b0, h_quo});
      sta_in.e = s1.e_zero ? 16'd0 : (s1.e_one ? tgov_pkg::ONE_Q15 : {1'b0, e_quo});
      h_boost  = {1'b0, sta_in.h} + {1'b0, tgov_pkg::SHADE_BOOST};
      if (s1.action) begin
         sta_in.act = s1.given;
      end else if (sta_in.h > tgov_pkg::HEAT_GATE && sta_in.e < tgov_pkg::ENERGY_MID) begin
         sta_in.act.shade_enable = 1'b1;
         sta_in.act.shade_level  = (h_boost > {1'b0, tgov_pkg::ONE_Q15}) ?
                                   tgov_pkg::ONE_Q15 : h_boost[15:0];
         sta_in.act.mist_on      = 1'b1;
         sta_in.act.mist_level   = tgov_pkg::MIST_HALF;
      end else if (sta_in.h > tgov_pkg::HEAT_GATE && sta_in.e <= tgov_pkg::ENERGY_HIGH) begin
         sta_in.act.shade_enable = 1'b1;
         sta_in.act.shade_level  = sta_in.h;
         sta_in.act.mist_on      = 1'b0;
         sta_in.act.mist_level   = 16'd0;
      end else if (sta_in.e > tgov_pkg::ENERGY_HIGH) begin
         sta_in.act.shade_enable = 1'b1;
         sta_in.act.shade_level  = tgov_pkg::SHADE_MIN;
         sta_in.act.mist_on      = 1'b0;
         sta_in.act.mist_level   = 16'd0;
      end else begin
         sta_in.act.shade_enable = 1'b0;
         sta_in.act.shade_level  = 16'd0;
         sta_in.act.mist_on      = 1'b0;
         sta_in.act.mist_level   = 16'd0;
      end
      sta_in.s_eff  = sta_in.act.shade_enable ? sta_in.act.shade_level : 16'd0;
      sta_in.m_eff  = sta_in.act.mist_on ? sta_in.act.mist_level : 16'd0;
      sta_in.charge = s1.charge;
      sta_in.t_diff = s1.t_diff;
      sta_in.h_span = s1.h_span;
   end

   // Stage B: temperature drop, drain and square products.
   stb_type stb_in, stb_ff;
   logic    vb_ff;
   logic [17:0] drop;

   always_comb begin
      drop = {1'b0, sta_ff.s_eff, 1'b0} + {2'b0, sta_ff.s_eff} + {2'b0, sta_ff.m_eff};
      stb_in.act        = sta_ff.act;
      stb_in.charge     = sta_ff.charge;
      stb_in.n_heat     = $signed({sta_ff.t_diff[16], sta_ff.t_diff, 7'b0})
                          - $signed({7'b0, drop});
      stb_in.h_span     = sta_ff.h_span;
      stb_in.shade_prod = shade_drain_ff * sta_ff.s_eff;
      stb_in.mist_prod  = mist_drain_ff * sta_ff.m_eff;
      stb_in.h_sq       = sta_ff.h * sta_ff.h;
      stb_in.e_sq       = sta_ff.e * sta_ff.e;
   end

   // Stage C: total drain, weighted current squares, next heat ramp limits.
   stc_type stc_in, stc_ff;
   logic    vc_ff;
   logic signed [24:0] nh_span;

   always_comb begin
      nh_span        = $signed({stb_ff.h_span[16], stb_ff.h_span, 7'b0});
      stc_in.act     = stb_ff.act;
      stc_in.charge  = stb_ff.charge;
      stc_in.drain   = {1'b0, stb_ff.shade_prod} + {1'b0, stb_ff.mist_prod};
      stc_in.p_h     = heat_weight_ff * stb_ff.h_sq;
      stc_in.p_e     = energy_weight_ff * stb_ff.e_sq;
      stc_in.nh_zero = stb_ff.n_heat <= 25'sd0;
      stc_in.nh_one  = stb_ff.n_heat >= nh_span;
      stc_in.nh_num  = stb_ff.n_heat[22:0];
      stc_in.nh_den  = nh_span[22:0];
   end

   // Stage D: next charge and current potential.
   std_type std_in, std_ff;
   logic    vd_ff;
   logic [48:0] c46;
   logic [48:0] c_left;
   logic [48:0] cp_sum;

   always_comb begin
      c46            = {2'b0, stc_ff.charge, 23'b0};
      c_left         = c46 - stc_ff.drain;
      cp_sum         = {1'b0, stc_ff.p_h} + {1'b0, stc_ff.p_e};
      std_in.act     = stc_ff.act;
      std_in.nc      = (stc_ff.drain >= c46) ? 24'd0 : c_left[46:23];
      std_in.cp      = cp_sum[47:30];
      std_in.nh_zero = stc_ff.nh_zero;
      std_in.nh_one  = stc_ff.nh_one;
      std_in.nh_num  = stc_ff.nh_num;
      std_in.nh_den  = stc_ff.nh_den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= v1_ff[QW-1];
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sta_ff <= sta_in;
         stb_ff <= stb_in;
         stc_ff <= stc_in;
         std_ff <= std_in;
      end
   end

   // Predicted risk ramps enter the second divider pair.
   side2_type side2_in;
   logic [23:0] ne_div_num, ne_div_den;

   always_comb begin
      side2_in.act     = std_ff.act;
      side2_in.nc      = std_ff.nc;
      side2_in.cp      = std_ff.cp;
      side2_in.nh_zero = std_ff.nh_zero;
      side2_in.nh_one  = std_ff.nh_one;
      side2_in.ne_zero = std_ff.nc >= tgov_pkg::CHARGE_FULL;
      side2_in.ne_one  = std_ff.nc <= charge_min_ff;
      ne_div_num       = tgov_pkg::CHARGE_FULL - std_ff.nc;
      ne_div_den       = tgov_pkg::CHARGE_FULL - charge_min_ff;
   end

   logic [QW-1:0] nh_quo, ne_quo;

   tgov_div #(.W(tgov_pkg::NEXT_HEAT_W), .QW(QW)) u_next_heat_div (
      .clock (clock), .en (en), .num (std_ff.nh_num), .den (std_ff.nh_den), .quo (nh_quo)
   );

   tgov_div #(.W(tgov_pkg::ENERGY_DIV_W), .QW(QW)) u_next_energy_div (
      .clock (clock), .en (en), .num (ne_div_num), .den (ne_div_den), .quo (ne_quo)
   );

   side2_type side2_ff [QW];
   logic [QW-1:0] v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= '0;
      end else if (en) begin
         v2_ff <= {v2_ff[QW-2:0], vd_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff[0] <= side2_in;
         for (int i = 1; i < QW; i++) begin
            side2_ff[i] <= side2_ff[i-1];
         end
      end
   end

   // Stage E: next risks, their squares and weighted terms.
   side2_type s2;
   ste_type   ste_in, ste_ff;
   logic      ve_ff;

   always_comb begin
      s2        = side2_ff[QW-1];
      ste_in.act = s2.act;
      ste_in.nc  = s2.nc;
      ste_in.cp  = s2.cp;
      ste_in.nh  = s2.nh_zero ? 16'd0 : (s2.nh_one ? tgov_pkg::ONE_Q15 : {1'b0, nh_quo});
      ste_in.ne  = s2.ne_zero ? 16'd0 : (s2.ne_one ? tgov_pkg::ONE_Q15 : {1'b0, ne_quo});
      ste_in.nh_sq = ste_in.nh * ste_in.nh;
      ste_in.ne_sq = ste_in.ne * ste_in.ne;
      ste_in.rs_h  = heat_weight_ff * ste_in.nh;
      ste_in.rs_e  = energy_weight_ff * ste_in.ne;
   end

   // Stage F: weighted squares and the risk sum.
   stf_type stf_in, stf_ff;
   logic [32:0] rs_sum;

   always_comb begin
      rs_sum     = {1'b0, ste_ff.rs_h} + {1'b0, ste_ff.rs_e};
      stf_in.act = ste_ff.act;
      stf_in.nc  = ste_ff.nc;
      stf_in.cp  = ste_ff.cp;
      stf_in.nh  = ste_ff.nh;
      stf_in.ne  = ste_ff.ne;
      stf_in.p_h = heat_weight_ff * ste_ff.nh_sq;
      stf_in.p_e = energy_weight_ff * ste_ff.ne_sq;
      stf_in.nr  = rs_sum[32:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= v2_ff[QW-1];
         vf_ff <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ste_ff <= ste_in;
         stf_ff <= stf_in;
      end
   end

   // Final stage: potential and verdict, packed into the result beat.
   logic [48:0] np_sum;
   logic [17:0] np;
   logic        lyap_ok, roh_ok, soc_ok, verdict;

   always_comb begin
      np_sum  = {1'b0, stf_ff.p_h} + {1'b0, stf_ff.p_e};
      np      = np_sum[47:30];
      lyap_ok = ({1'b0, np} + tgov_pkg::SLACK <= {1'b0, stf_ff.cp})
                || (stf_ff.nh == 16'd0 && stf_ff.ne == 16'd0);
      roh_ok  = stf_ff.nr <= {1'b0, risk_ceiling_ff};
      soc_ok  = stf_ff.nc >= charge_min_ff;
      verdict = !(lyap_ok && roh_ok && soc_ok);
      res_data = {3'b0, verdict, stf_ff.nc, stf_ff.nr[16:0], np[16:0],
                  stf_ff.ne, stf_ff.nh, stf_ff.act.mist_level, stf_ff.act.mist_on,
                  stf_ff.act.shade_level, stf_ff.act.shade_enable};
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_load_new  = 1'b0;
      out_load_skid = 1'b0;
      skid_load     = 1'b0;
      if (skid_valid_ff) begin
         if (take) begin
            out_load_skid = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (vf_ff) begin
         if (!out_valid_ff || take) begin
            out_load_new = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            skid_load     = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load_new) begin
         out_data_ff <= res_data;
      end else if (out_load_skid) begin
         out_data_ff <= skid_data_ff;
      end
      if (skid_load) begin
         skid_data_ff <= res_data;
      end
   end

endmodule
`default_nettype wire

// File: test/thermal_energy_action_governor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal energy action governor checker
// Watches the sample, result and register channels of the governor. It keeps
// its own copy of the registers and works out the expected result of every
// accepted sample. Each result beat is then compared, field by field, with
// the oldest expected one.
// ----------------------------------------------------------------------------
module thermal_energy_action_governor_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [79:0]  req_tdata,
   input  wire logic         req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data,
   output int                fail_count,
   output int                pending
);

   typedef struct {
      logic        shade_enable;
      logic [15:0] shade_level;
      logic        mist_on;
      logic [15:0] mist_level;
      logic [15:0] heat_risk;
      logic [15:0] energy_risk;
      logic [16:0] potential;
      logic [16:0] risk_sum;
      logic [23:0] charge;
      logic        verdict;
   } governor_result_type;

   logic [15:0] safe_temp;
   logic [15:0] harm_temp;
   logic [23:0] charge_min;
   logic [15:0] heat_wt;
   logic [15:0] energy_wt;
   logic [16:0] ceiling;
   logic [31:0] shade_drain;
   logic [31:0] mist_drain;

   governor_result_type expected_results[$];

   function automatic longint heat_ramp(longint t, longint lo, longint hi);
      if (t <= lo) return 0;
      if (t >= hi) return 32768;
      return ((t - lo) * 32768) / (hi - lo);
   endfunction

   function automatic longint energy_ramp(longint c);
      longint full;
      full = longint'(tgov_pkg::CHARGE_FULL);
      if (c >= full) return 0;
      if (c <= longint'(charge_min)) return 32768;
      return ((full - c) * 32768) / (full - longint'(charge_min));
   endfunction

   function automatic longint weighted_square(longint h, longint e);
      return (longint'(heat_wt) * h * h + longint'(energy_wt) * e * e) >> 30;
   endfunction

   function automatic longint saturate_level(logic [15:0] v);
      return (v > tgov_pkg::ONE_Q15) ? longint'(tgov_pkg::ONE_Q15) : longint'(v);
   endfunction

   function automatic governor_result_type forecast(logic act, logic [79:0] d);
      governor_result_type o;
      longint t, lo, hi, nt, h, e, s_lv, m_lv, s_eff, m_eff, c, drain, c46;
      longint nc, nh, ne, np, cp, nr;
      logic s_on, m_on;
      t  = longint'($signed(d[15:0])) * 128;
      lo = longint'($signed(safe_temp)) * 128;
      hi = longint'($signed(harm_temp)) * 128;
      c  = longint'(d[39:16]);
      h  = heat_ramp(t, lo, hi);
      e  = energy_ramp(c);
      if (act) begin
         s_on = d[40];
         s_lv = saturate_level(d[56:41]);
         m_on = d[57];
         m_lv = saturate_level(d[73:58]);
      end else if (h > tgov_pkg::HEAT_GATE && e < tgov_pkg::ENERGY_MID) begin
         s_on = 1'b1;
         s_lv = (h + tgov_pkg::SHADE_BOOST > tgov_pkg::ONE_Q15) ?
                longint'(tgov_pkg::ONE_Q15) : h + tgov_pkg::SHADE_BOOST;
         m_on = 1'b1;
         m_lv = tgov_pkg::MIST_HALF;
      end else if (h > tgov_pkg::HEAT_GATE && e <= tgov_pkg::ENERGY_HIGH) begin
         s_on = 1'b1; s_lv = h; m_on = 1'b0; m_lv = 0;
      end else if (e > tgov_pkg::ENERGY_HIGH) begin
         s_on = 1'b1; s_lv = tgov_pkg::SHADE_MIN; m_on = 1'b0; m_lv = 0;
      end else begin
         s_on = 1'b0; s_lv = 0; m_on = 1'b0; m_lv = 0;
      end
      s_eff = s_on ? s_lv : 0;
      m_eff = m_on ? m_lv : 0;
      nt = t - (3 * s_eff + m_eff);
      nh = heat_ramp(nt, lo, hi);
      drain = longint'(shade_drain) * s_eff + longint'(mist_drain) * m_eff;
      c46 = c << 23;
      nc = (drain >= c46) ? 0 : (c46 - drain) >> 23;
      ne = energy_ramp(nc);
      np = weighted_square(nh, ne);
      cp = weighted_square(h, e);
      nr = (longint'(heat_wt) * nh + longint'(energy_wt) * ne) >> 15;
      o.shade_enable = s_on;
      o.shade_level  = s_lv[15:0];
      o.mist_on      = m_on;
      o.mist_level   = m_lv[15:0];
      o.heat_risk    = nh[15:0];
      o.energy_risk  = ne[15:0];
      o.potential    = np[16:0];
      o.risk_sum     = nr[16:0];
      o.charge       = nc[23:0];
      o.verdict      = !(((np + longint'(tgov_pkg::SLACK) <= cp) || (nh == 0 && ne == 0))
                         && (nr <= longint'(ceiling))
                         && (nc >= longint'(charge_min)));
      return o;
   endfunction

   function automatic int field_differs(string name, longint exp_v, longint act_v);
      if (exp_v == act_v) return 0;
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      return 1;
   endfunction

   always @(posedge clock) begin
      governor_result_type exp_r;
      int errs;
      if (reset) begin
         safe_temp   <= tgov_pkg::SAFE_TEMPERATURE_RESET;
         harm_temp   <= tgov_pkg::HARM_TEMPERATURE_RESET;
         charge_min  <= tgov_pkg::CHARGE_MINIMUM_RESET;
         heat_wt     <= tgov_pkg::HEAT_WEIGHT_RESET;
         energy_wt   <= tgov_pkg::ENERGY_WEIGHT_RESET;
         ceiling     <= tgov_pkg::RISK_CEILING_RESET;
         shade_drain <= tgov_pkg::SHADE_DRAIN_RESET;
         mist_drain  <= tgov_pkg::MIST_DRAIN_RESET;
         fail_count  <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (tgov_pkg::csr_index_type'(csr_index))
               tgov_pkg::CSR_SAFE_TEMPERATURE: safe_temp   <= csr_data[15:0];
               tgov_pkg::CSR_HARM_TEMPERATURE: harm_temp   <= csr_data[15:0];
               tgov_pkg::CSR_CHARGE_MINIMUM:   charge_min  <= csr_data[23:0];
               tgov_pkg::CSR_HEAT_WEIGHT:      heat_wt     <= csr_data[15:0];
               tgov_pkg::CSR_ENERGY_WEIGHT:    energy_wt   <= csr_data[15:0];
               tgov_pkg::CSR_RISK_CEILING:     ceiling     <= csr_data[16:0];
               tgov_pkg::CSR_SHADE_DRAIN:      shade_drain <= csr_data;
               tgov_pkg::CSR_MIST_DRAIN:       mist_drain  <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(forecast(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("Result beat arrived with no sample outstanding.");
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               errs = 0;
               errs += field_differs("shade_enable", exp_r.shade_enable, rsp_tdata[0]);
               errs += field_differs("shade_level", exp_r.shade_level, rsp_tdata[16:1]);
               errs += field_differs("mist_on", exp_r.mist_on, rsp_tdata[17]);
               errs += field_differs("mist_level", exp_r.mist_level, rsp_tdata[33:18]);
               errs += field_differs("next_heat_risk", exp_r.heat_risk, rsp_tdata[49:34]);
               errs += field_differs("next_energy_risk", exp_r.energy_risk,
                                     rsp_tdata[65:50]);
               errs += field_differs("next_potential", exp_r.potential, rsp_tdata[82:66]);
               errs += field_differs("next_risk_sum", exp_r.risk_sum, rsp_tdata[99:83]);
               errs += field_differs("next_charge", exp_r.charge, rsp_tdata[123:100]);
               errs += field_differs("verdict", exp_r.verdict, rsp_tdata[124]);
               if (errs != 0) fail_count <= fail_count + 1;
            end
         end
      end
      pending <= expected_results.size();
   end

endmodule

// File: test/thermal_energy_action_governor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal energy action governor testbench
// Drives directed and random samples through the governor under several
// register settings and flow-control patterns, and reports the verdict of the
// checker that runs beside the unit.
// ----------------------------------------------------------------------------
module thermal_energy_action_governor_unit_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [31:0]  csr_data;
   int           fail_count;
   int           pending;
   int           sender_idle_pct;
   int           receiver_stall_pct;
   int           quiet_cycles;
   logic [31:0]  setting_table[8][8];

   thermal_energy_action_governor_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   thermal_energy_action_governor_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_sample(logic act, logic [15:0] temp, logic [23:0] chg,
                              logic s_on, logic [15:0] s_lv, logic m_on,
                              logic [15:0] m_lv);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'd0, m_lv, m_on, s_lv, s_on, chg, temp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_register(tgov_pkg::csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(int row);
      for (int i = 0; i < 8; i++)
         write_register(tgov_pkg::csr_index_type'(i), setting_table[row][i]);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_level();
      case ($urandom_range(3))
         0: return ($urandom_range(1) != 0) ? tgov_pkg::ONE_Q15 : 16'd0;
         1: return 16'($urandom);
         default: return 16'($urandom_range(32768));
      endcase
   endfunction

   task automatic send_random(int row);
      int lo_t, hi_t, tmp;
      logic [15:0] temp;
      logic [23:0] chg;
      lo_t = $signed(setting_table[row][0][15:0]);
      hi_t = $signed(setting_table[row][1][15:0]);
      if (lo_t > hi_t) begin
         tmp = lo_t; lo_t = hi_t; hi_t = tmp;
      end
      lo_t = (lo_t - 1500 < -32768) ? -32768 : lo_t - 1500;
      hi_t = (hi_t + 1500 > 32767) ? 32767 : hi_t + 1500;
      if ($urandom_range(99) < 30) temp = 16'($urandom);
      else temp = 16'(lo_t + int'($urandom_range(hi_t - lo_t)));
      if ($urandom_range(99) < 25) chg = 24'($urandom);
      else chg = 24'($urandom_range(8388608));
      send_sample(1'($urandom_range(1)), temp, chg, 1'($urandom_range(1)),
                  random_level(), 1'($urandom_range(1)), random_level());
   endtask

   initial begin
      setting_table[0] = '{32'd8960, 32'd11520, 32'd1677722, 32'd9830, 32'd9830,
                           32'd9830, 32'd3579139, 32'd14316558};
      setting_table[1] = '{32'h8000, 32'h7FFF, 32'd0, 32'd32768, 32'd32768,
                           32'd65536, 32'h80000000, 32'h80000000};
      setting_table[2] = '{32'd100, 32'hFF9C, 32'd8388608, 32'd0, 32'd0,
                           32'd0, 32'd0, 32'd0};
      setting_table[3] = '{32'h2300, 32'h2300, 32'hFFFFFF, 32'hFFFF, 32'hFFFF,
                           32'h1FFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
      setting_table[4] = '{32'h1E00, 32'h3200, 32'd4194304, 32'd20000, 32'd12000,
                           32'd30000, 32'd50000000, 32'd200000000};
      setting_table[5] = '{32'hF600, 32'h0A00, 32'd1000000, 32'd32768, 32'd0,
                           32'd20000, 32'd1000, 32'd7000000};
      setting_table[6] = '{32'h2300, 32'h2400, 32'd7000000, 32'd5000, 32'd30000,
                           32'd65536, 32'd300000000, 32'd30000000};
      setting_table[7] = setting_table[0];

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = tgov_pkg::CSR_SAFE_TEMPERATURE;
      csr_data = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      quiet_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples under the reset settings.
      send_sample(1'b0, 16'h8000, 24'd0, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'h7FFF, 24'd8388608, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'd8960, 24'd1677722, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'd11520, 24'hFFFFFF, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'd11000, 24'd8000000, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'd10500, 24'd4000000, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'd10500, 24'd6000000, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'd9000, 24'd2000000, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'd9000, 24'd7000000, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'd12000, 24'd8388607, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b1, 16'd11000, 24'd8388608, 1'b1, 16'd32768, 1'b1, 16'd32768);
      send_sample(1'b1, 16'd11000, 24'd8388608, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
      send_sample(1'b1, 16'd11000, 24'd5000000, 1'b0, 16'hFFFF, 1'b0, 16'd32768);
      send_sample(1'b1, 16'd11000, 24'd5000000, 1'b1, 16'd0, 1'b1, 16'd0);
      send_sample(1'b1, 16'd10000, 24'd10, 1'b1, 16'd20000, 1'b1, 16'd10000);
      send_sample(1'b1, 16'h7FFF, 24'hFFFFFF, 1'b1, 16'h7FFF, 1'b0, 16'h5555);
      send_sample(1'b1, 16'h8000, 24'h555555, 1'b0, 16'hAAAA, 1'b1, 16'h7FFF);
      send_sample(1'b1, 16'd9500, 24'd1677723, 1'b1, 16'd1, 1'b0, 16'd1);
      send_sample(1'b0, 16'd11519, 24'd1677721, 1'b0, 16'd0, 1'b0, 16'd0);
      send_sample(1'b0, 16'd8961, 24'd8388607, 1'b0, 16'd0, 1'b0, 16'd0);
      wait_until_idle();

      for (int row = 0; row < 8; row++) begin
         apply_setting(row);
         for (int mode = 0; mode < 4; mode++) begin
            case ((mode + row) % 4)
               0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
               1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
               2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
               default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
            endcase
            for (int n = 0; n < 45; n++) send_random(row);
         end
         sender_idle_pct = 0;
         receiver_stall_pct = 0;
         wait_until_idle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
